### rtl/knapsack_01_dp_solver_unit_macros.svh
// assertion macros shared by the knapsack solver rtl
`ifndef KNAPSACK_01_DP_SOLVER_UNIT_MACROS_SVH
`define KNAPSACK_01_DP_SOLVER_UNIT_MACROS_SVH

`ifndef SYNTHESIS

// same-cycle implication, checked outside reset
`define KDPS_ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked outside reset
`define KDPS_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst) (ante) |=> (cons)) \
        else $error(msg);

`else

`define KDPS_ASSERT_IMPLY(label, clk, rst, ante, cons, msg)
`define KDPS_ASSERT_NEXT(label, clk, rst, ante, cons, msg)

`endif

`endif

### rtl/kdps_pkg.sv
// shared types and fixed field widths of the knapsack solver
package kdps_pkg;

    // fixed field widths
    localparam int WT_W  = 8;
    localparam int BEN_W = 16;
    localparam int CAP_W = 8;
    localparam int SUM_W = 21;
    localparam int SEL_W = 6;

    // sequencer states
    typedef enum logic [2:0] {
        S_IDLE,
        S_UPD,
        S_DRAIN,
        S_TOT,
        S_TBI,
        S_TBR,
        S_TBC,
        S_EMIT
    } kdps_state_t;

endpackage

### rtl/knapsack_01_dp_solver_unit.sv
// knapsack solver: one item per start, row update in memory, trace-back on the last item
// each accepted item keeps busy high for one best-row update per load, then a drain state
// a last item adds a trace-back with one take-bit memory read per item
// then at most one result per cycle while scanning item numbers upward
// an ignored item past the maximum count leaves busy low, or runs only the answers if last
// reset clears count, overflow flag, capacity and sequencer; memories need no clearing pass
`include "knapsack_01_dp_solver_unit_macros.svh"

module knapsack_01_dp_solver_unit
    import kdps_pkg::*;
#(
    parameter int MAX_ITEMS    = 32,
    parameter int MAX_CAPACITY = 255,
    parameter int BENEFIT_BITS = 16
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    output logic             busy,
    input  logic [WT_W-1:0]  item_weight,
    input  logic [BEN_W-1:0] item_benefit,
    input  logic             last_item,
    input  logic             cfg_valid,
    output logic             cfg_ready,
    input  logic [CAP_W-1:0] cfg_data,
    output logic             result_valid,
    output logic [SEL_W-1:0] selected_item,
    output logic [SUM_W-1:0] total_benefit,
    output logic             overflow,
    output logic             last_result
);

    localparam int LOADS    = MAX_CAPACITY + 1;
    localparam int LD_W     = $clog2(LOADS);
    localparam int CMP_W    = (LD_W > WT_W) ? LD_W : WT_W;
    localparam int IW       = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;
    localparam int CW       = $clog2(MAX_ITEMS + 1);
    localparam int TK_DEPTH = 1 << (IW + LD_W);
    localparam logic [BEN_W-1:0] BEN_MASK = (BENEFIT_BITS >= BEN_W) ? {BEN_W{1'b1}} :
        BEN_W'((64'd1 << BENEFIT_BITS) - 64'd1);

    // control state
    kdps_state_t     state_reg, state_next;
    logic [CW-1:0]   count_reg;
    logic            overflow_reg;
    logic [CAP_W-1:0] capacity_reg;
    logic            p1_vld_reg;

    // item and pipeline payload
    logic [WT_W-1:0]  w_reg;
    logic [BEN_W-1:0] b_reg;
    logic             last_reg;
    logic             first_reg;
    logic [LD_W-1:0]  ld_reg;
    logic [LD_W-1:0]  p1_ld_reg;
    logic             p1_fit_reg;

    // trace-back and emit state
    logic [CW-1:0]        tb_row_reg;
    logic [LD_W-1:0]      tb_ld_reg;
    logic [SUM_W-1:0]     total_reg;
    logic [MAX_ITEMS-1:0] sel_mask_reg;
    logic [CW-1:0]        nsel_reg;
    logic [CW-1:0]        emit_cnt_reg;
    logic [IW-1:0]        idx_reg;

    // result registers
    logic             result_valid_reg;
    logic [SEL_W-1:0] selected_item_reg;
    logic [SUM_W-1:0] total_benefit_reg;
    logic             overflow_out_reg;
    logic             last_result_reg;

    // memories
    logic [SUM_W-1:0] best_mem [LOADS];
    logic             take_mem [TK_DEPTH];
    logic [WT_W-1:0]  wt_mem [MAX_ITEMS];
    logic [SUM_W-1:0] best_rd_a_reg;
    logic [SUM_W-1:0] best_rd_b_reg;
    logic             take_rd_reg;
    logic [WT_W-1:0]  wt_rd_reg;

    // memory controls
    logic [LD_W-1:0]    best_ra;
    logic [LD_W-1:0]    best_rb;
    logic               best_we;
    logic [LD_W-1:0]    best_wa;
    logic [SUM_W-1:0]   best_wd;
    logic               take_we;
    logic [IW+LD_W-1:0] take_wa;
    logic               take_wd;
    logic [IW+LD_W-1:0] take_ra;
    logic [IW-1:0]      wt_ra;

    // datapath signals
    logic [CMP_W-1:0] cap_eff;
    logic [LD_W-1:0]  cap_ld;
    logic [CMP_W-1:0] ld_ext;
    logic [CMP_W-1:0] w_ext;
    logic             w_fits;
    logic             issue_fit;
    logic [SUM_W-1:0] old_l;
    logic [SUM_W-1:0] old_lw;
    logic [SUM_W:0]   sum;
    logic [SUM_W-1:0] sat;
    logic             take_bit;
    logic [IW-1:0]    tb_row_m1;
    logic             accept;
    logic             room;
    logic             emit_fire;
    logic             emit_last;
    logic             emit_none;

    assign accept    = start && !busy;
    assign room      = count_reg < CW'(MAX_ITEMS);
    assign busy      = (state_reg != S_IDLE);
    assign cfg_ready = !busy;

    // effective capacity, clamped to the row size
    assign cap_eff = (CMP_W'(capacity_reg) > CMP_W'(MAX_CAPACITY)) ? CMP_W'(MAX_CAPACITY)
                                                                  : CMP_W'(capacity_reg);
    assign cap_ld  = LD_W'(cap_eff);

    // issue stage: fit test and second read address
    assign ld_ext    = CMP_W'(ld_reg);
    assign w_ext     = CMP_W'(w_reg);
    assign w_fits    = (w_ext <= ld_ext);
    assign issue_fit = w_fits && (ld_ext <= cap_eff);

    // write stage: saturating sum and strict compare, first item sees a zero row
    assign old_l    = first_reg ? '0 : best_rd_a_reg;
    assign old_lw   = first_reg ? '0 : best_rd_b_reg;
    assign sum      = {1'b0, old_lw} + (SUM_W + 1)'(b_reg);
    assign sat      = sum[SUM_W] ? {SUM_W{1'b1}} : sum[SUM_W-1:0];
    assign take_bit = p1_fit_reg && (sat > old_l);

    assign tb_row_m1 = IW'(tb_row_reg - CW'(1));

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    if (room)
                        state_next = S_UPD;
                    else if (last_item)
                        state_next = S_TOT;
                end
            end
            S_UPD:
            begin
                if (ld_reg == '0)
                    state_next = S_DRAIN;
            end
            S_DRAIN:
            begin
                state_next = last_reg ? S_TOT : S_IDLE;
            end
            S_TOT:
            begin
                state_next = S_TBI;
            end
            S_TBI:
            begin
                state_next = S_TBR;
            end
            S_TBR:
            begin
                state_next = (tb_row_reg == '0) ? S_EMIT : S_TBC;
            end
            S_TBC:
            begin
                state_next = S_TBR;
            end
            S_EMIT:
            begin
                if (emit_none || (emit_fire && emit_last))
                    state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // memory controls and emit decisions
    always_comb
    begin
        best_ra   = (state_reg == S_TOT) ? cap_ld : ld_reg;
        best_rb   = w_fits ? LD_W'(ld_ext - w_ext) : ld_reg;
        best_we   = p1_vld_reg;
        best_wa   = p1_ld_reg;
        best_wd   = take_bit ? sat : old_l;
        take_we   = p1_vld_reg;
        take_wa   = {IW'(count_reg), p1_ld_reg};
        take_wd   = take_bit;
        take_ra   = {tb_row_m1, tb_ld_reg};
        wt_ra     = tb_row_m1;
        emit_none = (state_reg == S_EMIT) && (nsel_reg == '0);
        emit_fire = (state_reg == S_EMIT) && (nsel_reg != '0) && sel_mask_reg[idx_reg];
        emit_last = (CW'(emit_cnt_reg + CW'(1)) == nsel_reg);
    end

    // best row memory, two read ports and one write port
    always_ff @(posedge clk)
    begin
        if (best_we)
            best_mem[best_wa] <= best_wd;
        best_rd_a_reg <= best_mem[best_ra];
        best_rd_b_reg <= best_mem[best_rb];
    end

    // take bit memory, row by item and load
    always_ff @(posedge clk)
    begin
        if (take_we)
            take_mem[take_wa] <= take_wd;
        take_rd_reg <= take_mem[take_ra];
    end

    // item weight memory for the trace-back
    always_ff @(posedge clk)
    begin
        if (accept && room)
            wt_mem[IW'(count_reg)] <= item_weight;
        wt_rd_reg <= wt_mem[wt_ra];
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            count_reg        <= '0;
            overflow_reg     <= 1'b0;
            capacity_reg     <= '0;
            p1_vld_reg       <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            p1_vld_reg       <= (state_reg == S_UPD);
            result_valid_reg <= emit_fire || emit_none;
            if (cfg_valid && cfg_ready)
                capacity_reg <= cfg_data;
            if (accept && !room)
                overflow_reg <= 1'b1;
            if (state_reg == S_DRAIN)
                count_reg <= CW'(count_reg + CW'(1));
            else if (emit_none || (emit_fire && emit_last))
                count_reg <= '0;
        end
    end

    // item capture and update sweep
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            w_reg     <= item_weight;
            b_reg     <= item_benefit & BEN_MASK;
            last_reg  <= last_item;
            first_reg <= (count_reg == '0);
            ld_reg    <= LD_W'(MAX_CAPACITY);
        end
        else if ((state_reg == S_UPD) && (ld_reg != '0))
        begin
            ld_reg <= ld_reg - LD_W'(1);
        end
        p1_ld_reg  <= ld_reg;
        p1_fit_reg <= issue_fit;
    end

    // trace-back through the take bits, then upward scan of the selection
    always_ff @(posedge clk)
    begin
        case (state_reg)
            S_TOT:
            begin
                tb_ld_reg    <= cap_ld;
                tb_row_reg   <= count_reg;
                sel_mask_reg <= '0;
                nsel_reg     <= '0;
            end
            S_TBI:
            begin
                total_reg <= best_rd_a_reg;
            end
            S_TBR:
            begin
                idx_reg      <= '0;
                emit_cnt_reg <= '0;
            end
            S_TBC:
            begin
                if (take_rd_reg)
                begin
                    sel_mask_reg[tb_row_m1] <= 1'b1;
                    nsel_reg                <= CW'(nsel_reg + CW'(1));
                    tb_ld_reg <= LD_W'(CMP_W'(tb_ld_reg) - CMP_W'(wt_rd_reg));
                end
                tb_row_reg <= tb_row_m1 == IW'(0) ? '0 : CW'(tb_row_reg - CW'(1));
            end
            S_EMIT:
            begin
                idx_reg <= IW'(idx_reg + IW'(1));
                if (emit_fire)
                    emit_cnt_reg <= CW'(emit_cnt_reg + CW'(1));
            end
            default:
            begin
            end
        endcase
    end

    // result registers
    always_ff @(posedge clk)
    begin
        selected_item_reg <= emit_none ? '0 : SEL_W'(CW'(idx_reg) + CW'(1));
        total_benefit_reg <= total_reg;
        overflow_out_reg  <= overflow_reg;
        last_result_reg   <= emit_none || emit_last;
    end

    assign result_valid  = result_valid_reg;
    assign selected_item = selected_item_reg;
    assign total_benefit = total_benefit_reg;
    assign overflow      = overflow_out_reg;
    assign last_result   = last_result_reg;

    // checks
    `KDPS_ASSERT_IMPLY(a_row_rw_apart, clk, rst_n, best_we && (state_reg == S_UPD), (best_ra < best_wa) && (best_rb < best_wa), "best row read meets pending write")
    `KDPS_ASSERT_IMPLY(a_count_bound, clk, rst_n, 1'b1, count_reg <= CW'(MAX_ITEMS), "item count past maximum")
    `KDPS_ASSERT_IMPLY(a_tb_row_valid, clk, rst_n, state_reg == S_TBC, tb_row_reg != '0, "trace-back below first item")
    `KDPS_ASSERT_IMPLY(a_clear_after_run, clk, rst_n, result_valid_reg && last_result_reg, count_reg == '0, "item count not cleared after answer")
    `KDPS_ASSERT_NEXT(a_start_update, clk, rst_n, accept && room, state_reg == S_UPD, "accepted item did not start the row update")

endmodule

### tb/testbench.sv
// self-checking testbench for the 0/1 knapsack solver: random item sets against a row predictor
module testbench;
    import kdps_pkg::*;

    localparam int N_SLOTS       = 32;
    localparam int TOP_LOAD      = 255;
    localparam int SETTLE_CYCLES = 320;
    localparam int QUIET_LIMIT   = 4000;
    localparam int TAIL_CYCLES   = 400;
    localparam int CALM_JOBS     = 30;
    localparam logic [SUM_W:0] SUM_CAP = 22'h1FFFFF;

    // what the sender does next
    typedef enum logic [1:0] {
        JOB_ITEM,
        JOB_CAP,
        JOB_DRAIN
    } job_kind_t;

    typedef struct packed {
        job_kind_t        kind;
        logic [WT_W-1:0]  wt;
        logic [BEN_W-1:0] ben;
        logic             fin;
    } job_t;

    typedef struct packed {
        logic [SEL_W-1:0] sel;
        logic [SUM_W-1:0] total;
        logic             ovf;
        logic             fin;
    } answer_t;

    logic             clk;
    logic             rst_n        = 1'b0;
    logic             start        = 1'b0;
    logic             busy;
    logic [WT_W-1:0]  item_weight  = '0;
    logic [BEN_W-1:0] item_benefit = '0;
    logic             last_item    = 1'b0;
    logic             cfg_valid    = 1'b0;
    logic             cfg_ready;
    logic [CAP_W-1:0] cfg_data     = '0;
    logic             result_valid;
    logic [SEL_W-1:0] selected_item;
    logic [SUM_W-1:0] total_benefit;
    logic             overflow;
    logic             last_result;

    // pending jobs and answers still to come
    job_t    job_q [$];
    answer_t answer_q [$];
    job_t    cur         = '0;
    logic    job_live    = 1'b0;
    int      gap_left    = 0;
    int      settle_left = 0;
    int      quiet_cnt   = 0;
    int      fail_cnt    = 0;

    // predictor state
    logic [SUM_W-1:0] best_row [0:TOP_LOAD];
    logic             take_bit [0:N_SLOTS-1][0:TOP_LOAD];
    logic [WT_W-1:0]  slot_wt  [0:N_SLOTS-1];
    int               slot_cnt;
    logic             ovf_seen;
    logic [CAP_W-1:0] cap_model;

    knapsack_01_dp_solver_unit u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .item_weight   (item_weight),
        .item_benefit  (item_benefit),
        .last_item     (last_item),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data),
        .result_valid  (result_valid),
        .selected_item (selected_item),
        .total_benefit (total_benefit),
        .overflow      (overflow),
        .last_result   (last_result)
    );

    // row update for one item, and on the last item the trace-back into answers
    function automatic void solve_item(input logic [WT_W-1:0] w, input logic [BEN_W-1:0] b,
                                       input logic fin);
        int             load;
        int             row;
        int             k;
        logic [SUM_W:0] sum_v;
        logic [SUM_W-1:0] total;
        int             picks [$];
        answer_t        ans;
        if (slot_cnt < N_SLOTS)
        begin
            slot_wt[slot_cnt] = w;
            // downward sweep keeps lower loads at their old values
            for (load = TOP_LOAD; load >= 0; load--)
            begin
                take_bit[slot_cnt][load] = 1'b0;
                if (load <= cap_model && w <= load)
                begin
                    sum_v = {1'b0, best_row[load - w]} + b;
                    if (sum_v > SUM_CAP)
                        sum_v = SUM_CAP;
                    if (sum_v > {1'b0, best_row[load]})
                    begin
                        best_row[load] = sum_v[SUM_W-1:0];
                        take_bit[slot_cnt][load] = 1'b1;
                    end
                end
            end
            slot_cnt++;
        end
        else
            ovf_seen = 1'b1;
        if (!fin)
            return;
        // trace back from the configured capacity, newest item first
        load  = cap_model;
        total = best_row[load];
        for (row = slot_cnt; row > 0; row--)
        begin
            if (take_bit[row-1][load])
            begin
                picks.push_front(row);
                load = load - slot_wt[row-1];
            end
        end
        ans.total = total;
        ans.ovf   = ovf_seen;
        if (picks.size() == 0)
        begin
            ans.sel = '0;
            ans.fin = 1'b1;
            answer_q.insert(answer_q.size(), ans);
        end
        else
        begin
            for (k = 0; k < picks.size(); k++)
            begin
                ans.sel = SEL_W'(picks[k]);
                ans.fin = (k == picks.size() - 1);
                answer_q.insert(answer_q.size(), ans);
            end
        end
        for (load = 0; load <= TOP_LOAD; load++)
            best_row[load] = '0;
        slot_cnt = 0;
    endfunction

    task automatic push_item(input int w, input int b, input logic fin);
        job_t j;
        j.kind = JOB_ITEM;
        j.wt   = WT_W'(w);
        j.ben  = BEN_W'(b);
        j.fin  = fin;
        job_q.insert(job_q.size(), j);
    endtask

    // capacity change only once the block has gone quiet
    task automatic push_cap(input int c);
        job_t j;
        j      = '0;
        j.kind = JOB_DRAIN;
        job_q.insert(job_q.size(), j);
        j.kind = JOB_CAP;
        j.wt   = WT_W'(c);
        job_q.insert(job_q.size(), j);
    endtask

    // clock
    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // driver: one job at a time, transfers retired at the edge they happen
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            start     <= 1'b0;
            cfg_valid <= 1'b0;
        end
        else
        begin
            if (start && !busy)
            begin
                solve_item(item_weight, item_benefit, last_item);
                job_live = 1'b0;
            end
            if (cfg_valid && cfg_ready)
            begin
                cap_model = cfg_data;
                job_live  = 1'b0;
            end
            // random idle bursts, none near the end
            if (gap_left > 0)
                gap_left--;
            else if (job_q.size() > CALM_JOBS && $urandom_range(0, 39) == 0)
                gap_left = $urandom_range(1, 15);
            if (!job_live && job_q.size() != 0)
            begin
                cur         = job_q.pop_front();
                job_live    = 1'b1;
                settle_left = SETTLE_CYCLES;
            end
            // hold until every answer is out and the block has settled
            if (job_live && cur.kind == JOB_DRAIN)
            begin
                if (answer_q.size() != 0)
                    settle_left = SETTLE_CYCLES;
                else if (settle_left > 0)
                    settle_left--;
                else
                    job_live = 1'b0;
            end
            start        <= job_live && cur.kind == JOB_ITEM && gap_left == 0;
            cfg_valid    <= job_live && cur.kind == JOB_CAP && (cfg_valid || gap_left == 0);
            item_weight  <= cur.wt;
            item_benefit <= cur.ben;
            last_item    <= cur.fin;
            cfg_data     <= cur.wt;
        end
    end

    // monitor: compare each result with the oldest answer
    always @(posedge clk)
    begin : result_check
        answer_t want;
        if (rst_n)
        begin
            if (result_valid)
            begin
                if (answer_q.size() == 0)
                begin
                    $error("unexpected result: selected_item %0d total_benefit %0d",
                           selected_item, total_benefit);
                    fail_cnt++;
                end
                else
                begin
                    want = answer_q.pop_front();
                    if (selected_item !== want.sel)
                    begin
                        $error("selected_item: expected %0d, actual %0d", want.sel, selected_item);
                        fail_cnt++;
                    end
                    if (total_benefit !== want.total)
                    begin
                        $error("total_benefit: expected %0d, actual %0d", want.total,
                               total_benefit);
                        fail_cnt++;
                    end
                    if (overflow !== want.ovf)
                    begin
                        $error("overflow: expected %0d, actual %0d", want.ovf, overflow);
                        fail_cnt++;
                    end
                    if (last_result !== want.fin)
                    begin
                        $error("last_result: expected %0d, actual %0d", want.fin, last_result);
                        fail_cnt++;
                    end
                end
            end
            quiet_cnt <= (result_valid || (start && !busy) || (cfg_valid && cfg_ready)) ?
                         0 : quiet_cnt + 1;
        end
    end

    // watchdog on cycles with no transfer at all
    initial
    begin
        while (quiet_cnt < QUIET_LIMIT)
            @(negedge clk);
        $display("FAIL knapsack_01_dp_solver_unit");
        $finish;
    end

    // stimulus, reset and end of run
    initial
    begin
        int k;
        int set_len;
        int rand_items;
        int cap_now;
        int w;
        int b;
        for (k = 0; k <= TOP_LOAD; k++)
            best_row[k] = '0;
        slot_cnt  = 0;
        ovf_seen  = 1'b0;
        cap_model = '0;

        // zero capacity: zero-weight item taken at load zero, zero benefit never
        push_cap(0);
        push_item(0, 100, 1'b0);
        push_item(5, 200, 1'b0);
        push_item(0, 0, 1'b1);
        // full capacity, heaviest item and largest benefit
        push_cap(255);
        push_item(255, 16'hFFFF, 1'b0);
        push_item(0, 0, 1'b0);
        push_item(1, 1, 1'b1);
        // nothing selected
        push_item(200, 0, 1'b1);
        // item too heavy, then capacity raised within the set
        push_cap(10);
        push_item(11, 500, 1'b0);
        push_item(3, 7, 1'b0);
        push_item(4, 9, 1'b0);
        push_item(3, 8, 1'b0);
        push_cap(20);
        push_item(12, 60, 1'b1);
        // zero capacity, nothing fits
        push_cap(0);
        push_item(1, 100, 1'b1);
        // alternating bit patterns
        push_cap(255);
        push_item(8'hAA, 16'h5555, 1'b0);
        push_item(8'h55, 16'hAAAA, 1'b0);
        push_item(8'h01, 16'h8001, 1'b1);

        // random sets, mostly short
        cap_now    = 255;
        rand_items = 0;
        while (rand_items < 150)
        begin
            if ($urandom_range(0, 2) == 0)
            begin
                case ($urandom_range(0, 3))
                    0:       cap_now = 0;
                    1:       cap_now = 255;
                    2:       cap_now = $urandom_range(1, 40);
                    default: cap_now = $urandom_range(0, 255);
                endcase
                push_cap(cap_now);
            end
            set_len = ($urandom_range(0, 7) == 0) ? $urandom_range(7, N_SLOTS) :
                      $urandom_range(1, 6);
            for (k = 0; k < set_len; k++)
            begin
                w = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 255) :
                    $urandom_range(0, cap_now);
                case ($urandom_range(0, 7))
                    0:       b = 0;
                    1:       b = 16'hFFFF;
                    default: b = $urandom_range(0, 16'hFFFF);
                endcase
                push_item(w, b, k == set_len - 1);
            end
            rand_items += set_len;
        end

        // full set, then items past the maximum count, the last one still answering
        push_cap(255);
        for (k = 0; k < N_SLOTS; k++)
            push_item($urandom_range(0, 20), $urandom_range(0, 16'hFFFF), 1'b0);
        push_item(7, 1234, 1'b0);
        push_item(3, 99, 1'b1);
        // flag stays up on later sets
        push_cap(30);
        for (k = 0; k < 9; k++)
            push_item($urandom_range(0, 30), $urandom_range(0, 16'hFFFF), k % 3 == 2);

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        while (job_q.size() != 0 || job_live)
            @(negedge clk);
        while (answer_q.size() != 0)
            @(negedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);
        if (fail_cnt == 0)
            $display("PASS knapsack_01_dp_solver_unit");
        else
            $display("FAIL knapsack_01_dp_solver_unit");
        $finish;
    end

endmodule
